// ----- rtl/bie_pkg.sv -----
package bie_pkg;

    localparam int NumCells = 4;
    localparam int CornersPerCell = 4;
    localparam int CornerIdxW = 2;
    localparam int CellIdxW = 2;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] RegPosLimit = 2'd0;
    localparam logic [CfgIdxW-1:0] RegVelLimit = 2'd1;
    localparam logic [CfgIdxW-1:0] RegAngLimit = 2'd2;
    localparam logic [CfgIdxW-1:0] RegThreshold = 2'd3;

    // symmetric P in Q.16, order (pos, angle, vel, rate)
    localparam logic signed [22:0] P00 = 23'sd68944;
    localparam logic signed [22:0] P01 = 23'sd79181;
    localparam logic signed [22:0] P02 = 23'sd16908;
    localparam logic signed [22:0] P03 = 23'sd13029;
    localparam logic signed [22:0] P11 = 23'sd2223859;
    localparam logic signed [22:0] P12 = 23'sd305601;
    localparam logic signed [22:0] P13 = 23'sd263907;
    localparam logic signed [22:0] P22 = 23'sd144887;
    localparam logic signed [22:0] P23 = 23'sd66126;
    localparam logic signed [22:0] P33 = 23'sd55208;

    typedef struct packed {
        logic signed [15:0] pmin;
        logic signed [15:0] pmax;
        logic signed [15:0] vmin;
        logic signed [15:0] vmax;
        logic signed [15:0] amin;
        logic signed [15:0] amax;
        logic signed [15:0] rmin;
        logic signed [15:0] rmax;
    } box_t;

    // token handed down the cell chain
    typedef struct packed {
        logic        valid;
        box_t        box;
        logic        ok;
        logic [31:0] best;
    } tok_t;

endpackage

// ----- rtl/bie_cell.sv -----
// One cell: evaluates 4 corners (fixed pos/vel choice), one per phase,
// then passes its running max to the next cell.
module bie_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           cell_idx,
    input  logic [1:0]           phase,
    input  logic                 step,
    input  bie_pkg::tok_t        tok_in,
    output bie_pkg::tok_t        tok_out
);

    bie_pkg::tok_t tok_reg;
    logic [31:0] best_reg, best_next;

    // stage 1: products
    bie_pkg::box_t box_sel;
    logic v_sel;
    logic load;
    logic signed [15:0] xp, xa, xv, xr;
    logic signed [31:0] spp, saa, svv, srr, spa, spv, spr, sav, sar, svr;
    logic signed [31:0] spp_reg, saa_reg, svv_reg, srr_reg, spa_reg, spv_reg;
    logic signed [31:0] spr_reg, sav_reg, sar_reg, svr_reg;
    logic v1_reg;
    logic signed [63:0] acc;
    logic [63:0] mag;
    logic [31:0] pot;

    // first corner straight from the incoming token, the rest from the held one
    always_comb begin
        box_sel = (phase == 2'd0) ? tok_in.box : tok_reg.box;
        v_sel = (phase == 2'd0) ? tok_in.valid : tok_reg.valid;
        // frozen while the chain is held at phase 0
        load = (phase != 2'd0) || step;
        xp = cell_idx[1] ? box_sel.pmax : box_sel.pmin;
        xv = cell_idx[0] ? box_sel.vmax : box_sel.vmin;
        xa = phase[1] ? box_sel.amax : box_sel.amin;
        xr = phase[0] ? box_sel.rmax : box_sel.rmin;
        spp = xp * xp; saa = xa * xa; svv = xv * xv; srr = xr * xr;
        spa = xp * xa; spv = xp * xv; spr = xp * xr;
        sav = xa * xv; sar = xa * xr; svr = xv * xr;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            spp_reg <= spp; saa_reg <= saa; svv_reg <= svv; srr_reg <= srr;
            spa_reg <= spa; spv_reg <= spv; spr_reg <= spr;
            sav_reg <= sav; sar_reg <= sar; svr_reg <= svr;
        end
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (load) begin
            v1_reg <= v_sel;
        end
    end

    // stage 2: weighted sum, clamp, round, saturate
    always_comb begin
        acc = 64'(bie_pkg::P00) * 64'(spp_reg) + 64'(bie_pkg::P11) * 64'(saa_reg)
            + 64'(bie_pkg::P22) * 64'(svv_reg) + 64'(bie_pkg::P33) * 64'(srr_reg)
            + 64'(2 * bie_pkg::P01) * 64'(spa_reg) + 64'(2 * bie_pkg::P02) * 64'(spv_reg)
            + 64'(2 * bie_pkg::P03) * 64'(spr_reg) + 64'(2 * bie_pkg::P12) * 64'(sav_reg)
            + 64'(2 * bie_pkg::P13) * 64'(sar_reg) + 64'(2 * bie_pkg::P23) * 64'(svr_reg);
        if (acc < 0) begin
            mag = 64'd0;
        end else begin
            mag = (64'(acc) + 64'h80_0000) >> 24;
        end
        pot = (mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
        best_next = best_reg;
        if (v1_reg && pot > best_next) begin
            best_next = pot;
        end
    end

    // token captured at phase 0; max accumulated over following cycles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            best_reg <= 32'd0;
        end else begin
            if (step) begin
                tok_reg <= tok_in;
            end
            if (phase == 2'd1 && v1_reg) begin
                best_reg <= (tok_reg.best > pot) ? tok_reg.best : pot;
            end else begin
                best_reg <= best_next;
            end
        end
    end

    // last corner folds in at phase 0, the cycle the next cell captures
    always_comb begin
        tok_out = tok_reg;
        tok_out.best = best_next;
    end

endmodule

// ----- rtl/box_in_ellipsoid_safety_check_unit.sv -----
// Box-in-ellipsoid check. A box is taken only at phase 0 and not while the chain
// is held; a chain of 4 cells each evaluates the 4 corners for one pos/vel choice,
// one corner per cycle while the chain is not held (a product stage and a
// weighted-sum stage per cell), and hands its running maximum to the next. A
// result waits in an output register; the chain stalls only while that register
// is full and not being taken, and the last cell holds a finished transaction.
module box_in_ellipsoid_safety_check_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_pos_min,
    input  logic signed [15:0] s_pos_max,
    input  logic signed [15:0] s_vel_min,
    input  logic signed [15:0] s_vel_max,
    input  logic signed [15:0] s_ang_min,
    input  logic signed [15:0] s_ang_max,
    input  logic signed [15:0] s_rate_min,
    input  logic signed [15:0] s_rate_max,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_within_limits,
    output logic        m_inside_ellipsoid,
    output logic [31:0] m_max_potential
);
    logic [14:0] pos_lim_reg, vel_lim_reg, ang_lim_reg;
    logic [31:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_lim_reg <= 15'd4096;
            vel_lim_reg <= 15'd4096;
            ang_lim_reg <= 15'd1072;
            thr_reg <= 32'd65536;
        end else if (cfg_we) begin
            case (cfg_idx)
                bie_pkg::RegPosLimit:  pos_lim_reg <= cfg_data[14:0];
                bie_pkg::RegVelLimit:  vel_lim_reg <= cfg_data[14:0];
                bie_pkg::RegAngLimit:  ang_lim_reg <= cfg_data[14:0];
                bie_pkg::RegThreshold: thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // phase counter; the chain advances at phase 0 unless output blocked
    logic [1:0] phase_reg;
    logic step;
    bie_pkg::tok_t tok [0:4];
    logic out_full_reg;

    assign step = (phase_reg == 2'd0);
    // hold at phase 0 when last token can't leave
    logic hold;
    assign hold = step && tok[4].valid && out_full_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
        end else if (!hold) begin
            phase_reg <= phase_reg + 2'd1;
        end
    end

    assign s_ready = step && !hold;

    function automatic logic lim_ok(input logic signed [15:0] lo,
                                    input logic signed [15:0] hi,
                                    input logic [14:0] l);
        logic signed [16:0] ls;
        begin
            ls = {2'b00, l};
            lim_ok = (17'(lo) >= -ls) && (17'(hi) <= ls);
        end
    endfunction

    always_comb begin
        tok[0].valid = s_valid && s_ready;
        tok[0].box = {s_pos_min, s_pos_max, s_vel_min, s_vel_max,
                      s_ang_min, s_ang_max, s_rate_min, s_rate_max};
        tok[0].ok = lim_ok(s_pos_min, s_pos_max, pos_lim_reg)
                  && lim_ok(s_vel_min, s_vel_max, vel_lim_reg)
                  && lim_ok(s_ang_min, s_ang_max, ang_lim_reg);
        tok[0].best = 32'd0;
    end

    for (genvar g = 0; g < 4; g++) begin : g_cell
        bie_cell u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .cell_idx(2'(g)), .phase(phase_reg), .step(step && !hold),
            .tok_in(tok[g]), .tok_out(tok[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full_reg <= 1'b0;
        end else begin
            if (out_full_reg && m_ready) out_full_reg <= 1'b0;
            if (step && !hold && tok[4].valid) begin
                out_full_reg <= 1'b1;
                m_within_limits <= tok[4].ok;
                m_inside_ellipsoid <= tok[4].best < thr_reg;
                m_max_potential <= tok[4].best;
            end
        end
    end
    assign m_valid = out_full_reg;

endmodule

// ----- rtl/bie_checker.sv -----
module bie_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_inside_ellipsoid,
    input logic [31:0] m_max_potential
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_max_potential))
        else $error("result dropped");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accept too soon");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_max_potential == 32'hFFFF_FFFF |-> !m_inside_ellipsoid)
        else $error("saturated but inside");
endmodule

bind box_in_ellipsoid_safety_check_unit bie_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_inside_ellipsoid(m_inside_ellipsoid), .m_max_potential(m_max_potential)
);

// ----- sim/tb_box_in_ellipsoid_safety_check_unit.sv -----
`timescale 1ns / 1ps

// Safety-check scoreboard: predicts the limit flag, the ellipsoid flag and the
// worst-corner potential for each accepted box, and compares results in order.
class box_check_scoreboard;
    typedef struct {
        logic        within_flag;
        logic        inside_flag;
        logic [31:0] potential;
    } verdict_t;

    verdict_t   pending[$];
    logic [14:0] pos_lim, vel_lim, ang_lim;
    logic [31:0] threshold;
    int          errors;

    function new();
        pos_lim   = 15'd4096;
        vel_lim   = 15'd4096;
        ang_lim   = 15'd1072;
        threshold = 32'd65536;
        errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            bie_pkg::RegPosLimit:  pos_lim = value[14:0];
            bie_pkg::RegVelLimit:  vel_lim = value[14:0];
            bie_pkg::RegAngLimit:  ang_lim = value[14:0];
            bie_pkg::RegThreshold: threshold = value;
            default: ;
        endcase
    endfunction

    // x'Px for one corner, clamped at zero, rounded half up, saturated
    function logic [31:0] corner_value(longint x[4]);
        longint p[4][4];
        longint acc;
        longint mag;
        p = '{'{68944, 79181, 16908, 13029},
              '{79181, 2223859, 305601, 263907},
              '{16908, 305601, 144887, 66126},
              '{13029, 263907, 66126, 55208}};
        acc = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                acc += p[i][j] * (x[i] * x[j]);
        if (acc < 0)
            acc = 0;
        mag = (acc + (64'sd1 <<< 23)) >>> 24;
        if (mag > 64'sh0FFFF_FFFF)
            mag = 64'sh0FFFF_FFFF;
        return mag[31:0];
    endfunction

    function void note_box(bie_pkg::box_t b);
        verdict_t v;
        longint x[4];
        logic [31:0] c;
        int pl, vl, al;
        pl = pos_lim;
        vl = vel_lim;
        al = ang_lim;
        v.within_flag = !(b.pmin < -pl || b.pmax > pl || b.vmin < -vl || b.vmax > vl ||
                          b.amin < -al || b.amax > al);
        v.potential = 0;
        for (int k = 0; k < 16; k++) begin
            x[0] = k[3] ? b.pmax : b.pmin;
            x[2] = k[2] ? b.vmax : b.vmin;
            x[1] = k[1] ? b.amax : b.amin;
            x[3] = k[0] ? b.rmax : b.rmin;
            c = corner_value(x);
            if (k == 0 || c > v.potential)
                v.potential = c;
        end
        v.inside_flag = v.potential < threshold;
        pending.push_back(v);
    endfunction

    function void check_result(logic lim_flag, logic ell_flag, logic [31:0] potential);
        verdict_t v;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result expected none actual %0d %0d %h",
                     $time, lim_flag, ell_flag, potential);
            errors++;
            return;
        end
        v = pending.pop_front();
        if (lim_flag !== v.within_flag) begin
            $display("%0t: within_limits expected %0d actual %0d", $time, v.within_flag,
                     lim_flag);
            errors++;
        end
        if (ell_flag !== v.inside_flag) begin
            $display("%0t: inside_ellipsoid expected %0d actual %0d", $time, v.inside_flag,
                     ell_flag);
            errors++;
        end
        if (potential !== v.potential) begin
            $display("%0t: max_potential expected %h actual %h", $time, v.potential,
                     potential);
            errors++;
        end
    endfunction
endclass

module tb_box_in_ellipsoid_safety_check_unit;

    localparam int LatencyCycles = 40;
    localparam int CycleLimit = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_pos_min = '0, s_pos_max = '0, s_vel_min = '0, s_vel_max = '0;
    logic signed [15:0] s_ang_min = '0, s_ang_max = '0, s_rate_min = '0, s_rate_max = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_within_limits, m_inside_ellipsoid;
    logic [31:0] m_max_potential;

    box_check_scoreboard board = new();
    int  cycle_count = 0;
    bit  idle_free = 1'b0;     // no random idling on either side while set
    bit  hold_sink = 1'b0;     // receiver held off for the backpressure phase

    always #5 aclk = ~aclk;

    box_in_ellipsoid_safety_check_unit i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_idx, .cfg_data,
        .s_valid, .s_ready,
        .s_pos_min, .s_pos_max, .s_vel_min, .s_vel_max,
        .s_ang_min, .s_ang_max, .s_rate_min, .s_rate_max,
        .m_valid, .m_ready, .m_within_limits, .m_inside_ellipsoid, .m_max_potential
    );

    // Watchdog: the slowest legal run is far below this.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random ready, checks each transaction at the edge it lands on.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_within_limits, m_inside_ellipsoid, m_max_potential);
        m_ready <= !hold_sink && (idle_free || $urandom_range(99) >= 23);
    end

    // One write, then write enable is dropped and the task waits with it low, so back-to-back writes never collide.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        board.set_reg(idx, value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one box and holds it until the input handshake completes.
    // Valid stays high afterwards; idling or drain() drops it.
    task automatic send_box(bie_pkg::box_t b);
        while (!idle_free && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_pos_min, s_pos_max, s_vel_min, s_vel_max,
         s_ang_min, s_ang_max, s_rate_min, s_rate_max} <= b;
        do @(posedge aclk); while (!s_ready);
        board.note_box(b);
    endtask

    // Drain the result queue plus pipeline slack, so config writes see an idle block.
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge aclk);
        repeat (LatencyCycles) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_val(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(8192))) - 16'sd4096;
            default: return $signed(16'($urandom_range(1200))) - 16'sd600;
        endcase
    endfunction

    // Mostly ordered boxes of modest size; some inverted or full-range ones.
    function automatic bie_pkg::box_t rand_box();
        bie_pkg::box_t b;
        logic signed [15:0] v[8];
        int mode;
        mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(1) ? 1 : 2);
        foreach (v[i])
            v[i] = rand_val(mode);
        if ($urandom_range(9) != 0)
            for (int i = 0; i < 8; i += 2)
                if (v[i] > v[i+1]) begin
                    v[i] ^= v[i+1]; v[i+1] ^= v[i]; v[i] ^= v[i+1];
                end
        b = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
        return b;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
            send_box(rand_box());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero box, extremes, inverted box, limit edges, saturation.
        send_box('0);
        send_box({16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                  16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
        send_box({8{16'sh7FFF}});
        send_box({8{16'sh8000}});
        send_box({8{16'shFFFF}});
        send_box({16'sh1000, -16'sh1000, 16'sh1000, -16'sh1000,
                  16'sh0430, -16'sh0430, 16'sh0010, -16'sh0010});
        send_box({-16'sh1000, 16'sh1000, -16'sh1000, 16'sh1000,
                  -16'sh0430, 16'sh0430, 16'sh0000, 16'sh0000});
        send_box({-16'sh1001, 16'sh1000, -16'sh1000, 16'sh1000,
                  -16'sh0430, 16'sh0430, 16'sh0000, 16'sh0000});
        send_box({-16'sh1000, 16'sh1000, -16'sh1000, 16'sh1001,
                  -16'sh0430, 16'sh0430, 16'sh0000, 16'sh0000});
        send_box({-16'sh1000, 16'sh1000, -16'sh1000, 16'sh1000,
                  -16'sh0430, 16'sh0431, 16'sh0000, 16'sh0000});
        send_box({16'sh0100, 16'sh0200, -16'sh0200, 16'sh0100,
                  16'sh0010, 16'sh0040, -16'sh0400, 16'sh0400});
        send_box({16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                  16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA});
        drain();

        // Zero limits, zero threshold: both flags mostly low.
        write_reg(bie_pkg::RegPosLimit, 32'h0);
        write_reg(bie_pkg::RegVelLimit, 32'h0);
        write_reg(bie_pkg::RegAngLimit, 32'h0);
        write_reg(bie_pkg::RegThreshold, 32'h0);
        send_box('0);
        random_phase(60);
        drain();

        // Widest limits, largest threshold.
        write_reg(bie_pkg::RegPosLimit, 32'hFFFF_FFFF);
        write_reg(bie_pkg::RegVelLimit, 32'h0000_7FFF);
        write_reg(bie_pkg::RegAngLimit, 32'h0000_7FFF);
        write_reg(bie_pkg::RegThreshold, 32'hFFFF_FFFF);
        random_phase(100);

        // Backpressure: receiver held off while the sender keeps offering boxes.
        fork
            begin
                hold_sink = 1'b1;
                repeat (200) @(posedge aclk);
                hold_sink = 1'b0;
            end
            random_phase(30);
        join
        drain();

        // Mid-range settings, then a burst with no idling.
        write_reg(bie_pkg::RegPosLimit, 32'h0000_2000);
        write_reg(bie_pkg::RegVelLimit, 32'h0000_0800);
        write_reg(bie_pkg::RegAngLimit, 32'h0000_0430);
        write_reg(bie_pkg::RegThreshold, 32'h0010_0000);
        idle_free = 1'b1;
        random_phase(120);
        idle_free = 1'b0;
        drain();

        write_reg(bie_pkg::RegThreshold, 32'h0000_4000);
        random_phase(180);
        drain();

        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
